// File: sv/status_led_blink_code_generator_top_macros.svh
`ifndef STATUS_LED_BLINK_CODE_GENERATOR_TOP_MACROS_SVH
`define STATUS_LED_BLINK_CODE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SLEDGEN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SLEDGEN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sledgen_pkg.sv
`timescale 1ns / 1ps

package sledgen_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int TIMER_BITS   = 10;
	localparam int CFG_W        = 10;
	localparam int CUR_W        = $clog2(SENSOR_COUNT);
	localparam int SBL_W        = $clog2(SENSOR_COUNT + 1);
	localparam int SNUM_W       = (CUR_W > 3) ? CUR_W : 3;
	localparam int CMP_W        = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	// Elapsed timer slots
	localparam int T_RUN_FLIP   = 0;
	localparam int T_RUN_PERIOD = 1;
	localparam int T_LINK       = 2;
	localparam int T_SEN_FLIP   = 3;
	localparam int T_SEN_PERIOD = 4;
	localparam int T_FLT_FLIP   = 5;
	localparam int T_FLT_PERIOD = 6;
	localparam int T_COUNT      = 7;

	localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_LINK    = 3'd1,
		CMD_SENSOR  = 3'd2,
		CMD_DB      = 3'd3,
		CMD_STORAGE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_RUN_FLIP_ACTIVE = 3'd0,
		REG_RUN_FLIP_IDLE   = 3'd1,
		REG_RUN_PERIOD      = 3'd2,
		REG_LINK_TIMEOUT    = 3'd3,
		REG_SENSOR_FLIP     = 3'd4,
		REG_SENSOR_PERIOD   = 3'd5,
		REG_FAULT_FLIP      = 3'd6,
		REG_FAULT_PERIOD    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] run_flip_active;
		logic [CFG_W-1:0] run_flip_idle;
		logic [CFG_W-1:0] run_period;
		logic [CFG_W-1:0] link_timeout;
		logic [CFG_W-1:0] sensor_flip;
		logic [CFG_W-1:0] sensor_period;
		logic [CFG_W-1:0] fault_flip;
		logic [CFG_W-1:0] fault_period;
	} cfg_regs_t;

	localparam cfg_regs_t CFG_RESET = '{
		run_flip_active: 10'd20,
		run_flip_idle:   10'd4,
		run_period:      10'd40,
		link_timeout:    10'd100,
		sensor_flip:     10'd4,
		sensor_period:   10'd60,
		fault_flip:      10'd5,
		fault_period:    10'd60
	};

	typedef struct packed {
		logic [2:0] command;
		logic [2:0] sensor_number;
		logic       status_value;
	} item_t;

	typedef struct packed {
		logic fault;
		logic sensor;
		logic run;
	} pins_t;

	// Timer expiry: counter has reached its limit
	function automatic logic fires(logic [TIMER_BITS-1:0] cnt, logic [CFG_W-1:0] lim);
		return CMP_W'(cnt) >= CMP_W'(lim);
	endfunction

	// Step the sensor cursor, wrapping at the sensor count
	function automatic logic [CUR_W-1:0] cur_inc(logic [CUR_W-1:0] c);
		return (c == CUR_W'(SENSOR_COUNT - 1)) ? '0 : CUR_W'(c + 1'b1);
	endfunction

endpackage

// File: sv/status_led_blink_code_generator_top.sv
// A word accepted into the input register updates the pin levels when it moves on into the result register.
// Throughput: one word per cycle; the block stalls only while a result is
// held by out_stall and the input register is full.
// Reset: arst_n low clears the registers to their defaults, all pins high
// (LEDs dark), link active, no errors and all timers at zero.
`timescale 1ns / 1ps

module status_led_blink_code_generator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [2:0] sensor_number,
	input  logic       status_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       run_pin,
	output logic       sensor_pin,
	output logic       fault_pin,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import sledgen_pkg::*;

	`include "status_led_blink_code_generator_top_macros.svh"

	cfg_regs_t regs;
	item_t     item_s1;
	logic      valid_s1;
	logic      out_valid_q;
	logic      adv;
	pins_t     pins;
	pins_t     pins_prev_q;

	// Result register is free or being drained
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign out_valid = out_valid_q;

	assign run_pin    = pins.run;
	assign sensor_pin = pins.sensor;
	assign fault_pin  = pins.fault;

	// Input and result register valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= '{command: command, sensor_number: sensor_number,
				status_value: status_value};
	end

	// Keep last pins for checking
	always_ff @(posedge clk) begin
		pins_prev_q <= pins;
	end

	sledgen_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	sledgen_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (valid_s1 && adv),
		.item   (item_s1),
		.cfg    (regs),
		.pins   (pins)
	);

	`SLEDGEN_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_valid && out_stall,
		"input stalled while result side is free")
	`SLEDGEN_ASSERT_NEXT(a_result_follows, valid_s1 && adv, out_valid,
		"processed word produced no result")
	`SLEDGEN_ASSERT_NEXT(a_status_keeps_pins, valid_s1 && adv && item_s1.command != CMD_TICK,
		pins == pins_prev_q, "status update moved LED pins")

endmodule

// File: sv/sledgen_cfg.sv
`timescale 1ns / 1ps

module sledgen_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [9:0]            cfg_data,
	output sledgen_pkg::cfg_regs_t regs
);
	import sledgen_pkg::*;

	cfg_regs_t regs_q;

	// Always take a config word
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_RUN_FLIP_ACTIVE: regs_q.run_flip_active <= cfg_data;
				REG_RUN_FLIP_IDLE:   regs_q.run_flip_idle   <= cfg_data;
				REG_RUN_PERIOD:      regs_q.run_period      <= cfg_data;
				REG_LINK_TIMEOUT:    regs_q.link_timeout    <= cfg_data;
				REG_SENSOR_FLIP:     regs_q.sensor_flip     <= cfg_data;
				REG_SENSOR_PERIOD:   regs_q.sensor_period   <= cfg_data;
				REG_FAULT_FLIP:      regs_q.fault_flip      <= cfg_data;
				REG_FAULT_PERIOD:    regs_q.fault_period    <= cfg_data;
				default:             regs_q <= regs_q;
			endcase
		end
	end

endmodule

// File: sv/sledgen_core.sv
`timescale 1ns / 1ps

module sledgen_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   proc,
	input  sledgen_pkg::item_t     item,
	input  sledgen_pkg::cfg_regs_t cfg,
	output sledgen_pkg::pins_t     pins
);
	import sledgen_pkg::*;

	localparam int IDX_W = CUR_W + 1;

	typedef struct packed {
		logic                               run_off;
		logic                               sensor_off;
		logic                               fault_off;
		pins_t                              pin;
		logic                               link_active;
		logic [SENSOR_COUNT-1:0]            sen_err;
		logic                               db_fault;
		logic                               st_fault;
		logic [CUR_W-1:0]                   cursor;
		logic [1:0]                         run_blinks;
		logic [SBL_W-1:0]                   sen_blinks;
		logic [1:0]                         flt_blinks;
		logic [T_COUNT-1:0][TIMER_BITS-1:0] cnt;
	} core_state_t;

	localparam core_state_t STATE_RESET = '{
		run_off:     1'b0,
		sensor_off:  1'b0,
		fault_off:   1'b0,
		pin:         '1,
		link_active: 1'b1,
		sen_err:     '0,
		db_fault:    1'b0,
		st_fault:    1'b0,
		cursor:      '0,
		run_blinks:  '0,
		sen_blinks:  '0,
		flt_blinks:  '0,
		cnt:         '0
	};

	core_state_t      st_q;
	core_state_t      st_d;
	logic [CUR_W-1:0] found;

	assign pins = st_q.pin;

	// Find the first erroring sensor at or after the cursor, wrapping round
	always_comb begin
		logic [IDX_W-1:0] idx;
		idx   = '0;
		found = st_q.cursor;
		for (int k = SENSOR_COUNT - 1; k >= 0; k--) begin
			idx = IDX_W'(st_q.cursor) + IDX_W'(k);
			if (idx >= IDX_W'(SENSOR_COUNT))
				idx = IDX_W'(idx - IDX_W'(SENSOR_COUNT));
			if (st_q.sen_err[idx[CUR_W-1:0]])
				found = idx[CUR_W-1:0];
		end
	end

	// Next state for one word
	always_comb begin
		logic             rp_fire, lk_fire, rf_fire;
		logic             sp_fire, sf_fire, fp_fire, ff_fire;
		logic [CFG_W-1:0] flip_lim;
		logic [1:0]       run_max;
		logic [SBL_W-1:0] sen_max;
		logic [1:0]       fcode;
		logic [SNUM_W-1:0] snum;

		st_d     = st_q;
		rp_fire  = 1'b0;
		lk_fire  = 1'b0;
		rf_fire  = 1'b0;
		sp_fire  = 1'b0;
		sf_fire  = 1'b0;
		fp_fire  = 1'b0;
		ff_fire  = 1'b0;
		flip_lim = '0;
		run_max  = '0;
		sen_max  = '0;
		fcode    = {st_q.db_fault, st_q.st_fault};
		snum     = SNUM_W'(item.sensor_number);

		if (proc) begin
			case (cmd_t'(item.command))
				CMD_TICK: begin
					// Running LED: period restart, link timeout, then toggle
					rp_fire = fires(st_q.cnt[T_RUN_PERIOD], cfg.run_period);
					if (rp_fire)
						st_d.run_blinks = '0;
					lk_fire = fires(st_q.cnt[T_LINK], cfg.link_timeout);
					if (lk_fire)
						st_d.link_active = 1'b0;
					flip_lim = st_d.link_active ? cfg.run_flip_active : cfg.run_flip_idle;
					run_max  = st_d.link_active ? 2'd1 : 2'd3;
					rf_fire  = fires(st_q.cnt[T_RUN_FLIP], flip_lim);
					if (rf_fire) begin
						st_d.run_off = (st_d.run_blinks < run_max) ? ~st_q.run_off : 1'b1;
						st_d.pin.run = st_d.run_off;
						if (!st_d.run_off)
							st_d.run_blinks = 2'(st_d.run_blinks + 2'd1);
					end

					// Sensor LED: blink the current erroring sensor index plus one
					if (|st_q.sen_err) begin
						st_d.cursor = found;
						sen_max     = SBL_W'(SBL_W'(found) + 1'b1);
						sp_fire     = fires(st_q.cnt[T_SEN_PERIOD], cfg.sensor_period);
						if (sp_fire) begin
							st_d.sen_blinks = '0;
							st_d.cursor     = cur_inc(found);
						end
						sf_fire = fires(st_q.cnt[T_SEN_FLIP], cfg.sensor_flip);
						if (sf_fire) begin
							st_d.sensor_off = (st_d.sen_blinks < sen_max) ?
								~st_q.sensor_off : 1'b1;
							st_d.pin.sensor = st_d.sensor_off;
							if (!st_d.sensor_off)
								st_d.sen_blinks = SBL_W'(st_d.sen_blinks + 1'b1);
						end
					end else begin
						st_d.sensor_off = 1'b1;
						st_d.pin.sensor = 1'b1;
						st_d.sen_blinks = '0;
					end

					// Error LED: blink storage plus twice database
					if (fcode == 2'd0) begin
						st_d.fault_off  = 1'b1;
						st_d.pin.fault  = 1'b1;
						st_d.flt_blinks = '0;
					end else begin
						fp_fire = fires(st_q.cnt[T_FLT_PERIOD], cfg.fault_period);
						if (fp_fire)
							st_d.flt_blinks = '0;
						ff_fire = fires(st_q.cnt[T_FLT_FLIP], cfg.fault_flip);
						if (ff_fire) begin
							st_d.fault_off = (st_d.flt_blinks < fcode) ?
								~st_q.fault_off : 1'b1;
							st_d.pin.fault = st_d.fault_off;
							if (!st_d.fault_off)
								st_d.flt_blinks = 2'(st_d.flt_blinks + 2'd1);
						end
					end

					// Advance timers: saturate, a fired timer restarts at one
					for (int i = 0; i < T_COUNT; i++) begin
						if (st_q.cnt[i] != CNT_MAX)
							st_d.cnt[i] = TIMER_BITS'(st_q.cnt[i] + 1'b1);
					end
					if (rp_fire) st_d.cnt[T_RUN_PERIOD] = TIMER_BITS'(1);
					if (lk_fire) st_d.cnt[T_LINK]       = TIMER_BITS'(1);
					if (rf_fire) st_d.cnt[T_RUN_FLIP]   = TIMER_BITS'(1);
					if (sp_fire) st_d.cnt[T_SEN_PERIOD] = TIMER_BITS'(1);
					if (sf_fire) st_d.cnt[T_SEN_FLIP]   = TIMER_BITS'(1);
					if (fp_fire) st_d.cnt[T_FLT_PERIOD] = TIMER_BITS'(1);
					if (ff_fire) st_d.cnt[T_FLT_FLIP]   = TIMER_BITS'(1);
				end
				CMD_LINK: begin
					st_d.link_active = item.status_value;
					if (item.status_value)
						st_d.cnt[T_LINK] = '0;
				end
				CMD_SENSOR: begin
					// Out-of-range sensor numbers match no bit
					for (int i = 0; i < SENSOR_COUNT; i++) begin
						if (snum == SNUM_W'(i))
							st_d.sen_err[i] = item.status_value;
					end
				end
				CMD_DB:      st_d.db_fault = item.status_value;
				CMD_STORAGE: st_d.st_fault = item.status_value;
				default:     st_d = st_q;
			endcase
		end
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import sledgen_pkg::*;

	// Command codes the block does not decode
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] command;
	logic [2:0] sensor_number;
	logic status_value;
	logic out_valid;
	logic out_stall;
	logic run_pin;
	logic sensor_pin;
	logic fault_pin;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;

	// Predicted block state
	logic [CFG_W-1:0] limit_reg [8];
	logic [TIMER_BITS-1:0] elapsed [T_COUNT];
	logic run_off, sen_off, flt_off;
	pins_t pins_now;
	logic link_up;
	logic [SENSOR_COUNT-1:0] sensor_err;
	logic db_err, st_err;
	logic [CUR_W-1:0] cursor;
	logic [1:0] run_blinks;
	logic [SBL_W-1:0] sensor_blinks;
	logic [1:0] fault_blinks;

	pins_t pins_due [$];
	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int reports;
	int words_in;
	int results_checked;
	int reg_writes;

	status_led_blink_code_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.sensor_number(sensor_number),
		.status_value(status_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.run_pin(run_pin),
		.sensor_pin(sensor_pin),
		.fault_pin(fault_pin),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Load the post-reset state into the predictor
	task automatic clear_model();
		limit_reg[REG_RUN_FLIP_ACTIVE] = CFG_RESET.run_flip_active;
		limit_reg[REG_RUN_FLIP_IDLE]   = CFG_RESET.run_flip_idle;
		limit_reg[REG_RUN_PERIOD]      = CFG_RESET.run_period;
		limit_reg[REG_LINK_TIMEOUT]    = CFG_RESET.link_timeout;
		limit_reg[REG_SENSOR_FLIP]     = CFG_RESET.sensor_flip;
		limit_reg[REG_SENSOR_PERIOD]   = CFG_RESET.sensor_period;
		limit_reg[REG_FAULT_FLIP]      = CFG_RESET.fault_flip;
		limit_reg[REG_FAULT_PERIOD]    = CFG_RESET.fault_period;
		for (int t = 0; t < T_COUNT; t++)
			elapsed[t] = '0;
		run_off = 1'b0;
		sen_off = 1'b0;
		flt_off = 1'b0;
		pins_now = '1;
		link_up = 1'b1;
		sensor_err = '0;
		db_err = 1'b0;
		st_err = 1'b0;
		cursor = '0;
		run_blinks = '0;
		sensor_blinks = '0;
		fault_blinks = '0;
	endtask

	function automatic logic [CUR_W-1:0] next_sensor(logic [CUR_W-1:0] c);
		return (c == CUR_W'(SENSOR_COUNT - 1)) ? '0 : CUR_W'(c + 1'b1);
	endfunction

	// Advance all blink timers by one tick
	function automatic void tick_leds();
		logic [CFG_W-1:0] flip_lim;
		logic [1:0] run_max;
		logic [SBL_W-1:0] sen_max;
		logic [1:0] code;
		int i;
		// running LED: period restart, link timeout, then toggle
		if (elapsed[T_RUN_PERIOD] >= limit_reg[REG_RUN_PERIOD]) begin
			elapsed[T_RUN_PERIOD] = '0;
			run_blinks = '0;
		end
		if (elapsed[T_LINK] >= limit_reg[REG_LINK_TIMEOUT]) begin
			elapsed[T_LINK] = '0;
			link_up = 1'b0;
		end
		if (link_up) begin
			flip_lim = limit_reg[REG_RUN_FLIP_ACTIVE];
			run_max = 2'd1;
		end else begin
			flip_lim = limit_reg[REG_RUN_FLIP_IDLE];
			run_max = 2'd3;
		end
		if (elapsed[T_RUN_FLIP] >= flip_lim) begin
			elapsed[T_RUN_FLIP] = '0;
			run_off = (run_blinks < run_max) ? ~run_off : 1'b1;
			pins_now.run = run_off;
			if (!run_off)
				run_blinks++;
		end
		// sensor LED: settle the cursor on an erroring sensor first
		if (sensor_err != '0) begin
			for (i = 0; i < SENSOR_COUNT && !sensor_err[cursor]; i++)
				cursor = next_sensor(cursor);
			sen_max = SBL_W'(cursor) + 1'b1;
			if (elapsed[T_SEN_PERIOD] >= limit_reg[REG_SENSOR_PERIOD]) begin
				elapsed[T_SEN_PERIOD] = '0;
				sensor_blinks = '0;
				cursor = next_sensor(cursor);
			end
			if (elapsed[T_SEN_FLIP] >= limit_reg[REG_SENSOR_FLIP]) begin
				elapsed[T_SEN_FLIP] = '0;
				sen_off = (sensor_blinks < sen_max) ? ~sen_off : 1'b1;
				pins_now.sensor = sen_off;
				if (!sen_off)
					sensor_blinks++;
			end
		end else begin
			sen_off = 1'b1;
			pins_now.sensor = 1'b1;
			sensor_blinks = '0;
		end
		// general error LED: storage counts one, database two
		code = {db_err, st_err};
		if (code == 2'd0) begin
			flt_off = 1'b1;
			pins_now.fault = 1'b1;
			fault_blinks = '0;
		end else begin
			if (elapsed[T_FLT_PERIOD] >= limit_reg[REG_FAULT_PERIOD]) begin
				elapsed[T_FLT_PERIOD] = '0;
				fault_blinks = '0;
			end
			if (elapsed[T_FLT_FLIP] >= limit_reg[REG_FAULT_FLIP]) begin
				elapsed[T_FLT_FLIP] = '0;
				flt_off = (fault_blinks < code) ? ~flt_off : 1'b1;
				pins_now.fault = flt_off;
				if (!flt_off)
					fault_blinks++;
			end
		end
		// saturate timers at full scale
		for (i = 0; i < T_COUNT; i++)
			if (elapsed[i] != '1)
				elapsed[i]++;
	endfunction

	// Apply one word and return the pin levels it leaves behind
	function automatic pins_t predict_pins(item_t w);
		case (w.command)
			CMD_TICK: tick_leds();
			CMD_LINK: begin
				link_up = w.status_value;
				if (w.status_value)
					elapsed[T_LINK] = '0;
			end
			CMD_SENSOR: begin
				if (w.sensor_number < SENSOR_COUNT)
					sensor_err[w.sensor_number] = w.status_value;
			end
			CMD_DB: db_err = w.status_value;
			CMD_STORAGE: st_err = w.status_value;
			default: ;
		endcase
		return pins_now;
	endfunction

	// Check results, track register writes, predict accepted words
	always @(posedge clk) begin : scoreboard
		pins_t got;
		pins_t want;
		item_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{fault: fault_pin, sensor: sensor_pin, run: run_pin};
				if (pins_due.size() == 0) begin
					fail_count++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("%0t: unexpected result: run %b sensor %b fault %b",
							$realtime, got.run, got.sensor, got.fault);
					end
				end else begin
					want = pins_due.pop_front();
					results_checked++;
					if (got.run !== want.run || got.sensor !== want.sensor ||
							got.fault !== want.fault) begin
						fail_count++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("%0t: exp/got run %b/%b sensor %b/%b fault %b/%b",
								$realtime, want.run, got.run, want.sensor, got.sensor,
								want.fault, got.fault);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				limit_reg[cfg_index] = cfg_data;
				reg_writes++;
			end
			if (in_valid && !in_stall) begin
				w = '{command: command, sensor_number: sensor_number,
					status_value: status_value};
				pins_due.push_back(predict_pins(w));
				words_in++;
			end
		end
	end

	// Stall the result side at the current rate
	always @(posedge clk)
		out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

	// End the run if nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Send one word, with an optional random gap ahead of it
	task automatic send_word(input logic [2:0] cmd, input logic [2:0] sensor,
			input logic value);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		sensor_number <= sensor;
		status_value <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every pending result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pins_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all eight limit registers
	task automatic apply_limits(input cfg_regs_t s);
		logic [CFG_W-1:0] vals [8];
		vals[REG_RUN_FLIP_ACTIVE] = s.run_flip_active;
		vals[REG_RUN_FLIP_IDLE]   = s.run_flip_idle;
		vals[REG_RUN_PERIOD]      = s.run_period;
		vals[REG_LINK_TIMEOUT]    = s.link_timeout;
		vals[REG_SENSOR_FLIP]     = s.sensor_flip;
		vals[REG_SENSOR_PERIOD]   = s.sensor_period;
		vals[REG_FAULT_FLIP]      = s.fault_flip;
		vals[REG_FAULT_PERIOD]    = s.fault_period;
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic cfg_regs_t random_limits(int hi);
		cfg_regs_t s;
		s.run_flip_active = CFG_W'($urandom_range(hi, 1));
		s.run_flip_idle   = CFG_W'($urandom_range(hi, 1));
		s.run_period      = CFG_W'($urandom_range(hi, 1));
		s.link_timeout    = CFG_W'($urandom_range(hi, 1));
		s.sensor_flip     = CFG_W'($urandom_range(hi, 1));
		s.sensor_period   = CFG_W'($urandom_range(hi, 1));
		s.fault_flip      = CFG_W'($urandom_range(hi, 1));
		s.fault_period    = CFG_W'($urandom_range(hi, 1));
		return s;
	endfunction

	// Mostly ticks, with status updates and undecoded commands mixed in
	task automatic random_stream(input int words);
		int pick;
		logic [2:0] cmd;
		repeat (words) begin
			pick = $urandom_range(99);
			if (pick < 62)
				cmd = CMD_TICK;
			else if (pick < 70)
				cmd = CMD_LINK;
			else if (pick < 84)
				cmd = CMD_SENSOR;
			else if (pick < 90)
				cmd = CMD_DB;
			else if (pick < 96)
				cmd = CMD_STORAGE;
			else
				cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			send_word(cmd, 3'($urandom_range(SENSOR_COUNT - 1)), 1'($urandom_range(1)));
		end
	endtask

	// Every command at reset limits, ignored fields held both high and low
	task automatic test_command_set();
		send_word(CMD_TICK, 3'd7, 1'b1);
		send_word(CMD_LINK, 3'd0, 1'b0);
		send_word(CMD_LINK, 3'd7, 1'b1);
		send_word(CMD_SENSOR, 3'd0, 1'b1);
		send_word(CMD_SENSOR, 3'd7, 1'b1);
		send_word(CMD_DB, 3'd0, 1'b1);
		send_word(CMD_STORAGE, 3'd0, 1'b1);
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			send_word(3'(c), 3'd7, 1'b1);
		send_word(CMD_TICK, 3'd0, 1'b0);
		wait_idle();
	endtask

	// Zero limits fire every tick; cursor wraps between sensors 7 and 0
	task automatic test_zero_limits();
		apply_limits('0);
		repeat (4) send_word(CMD_TICK, 3'd0, 1'b0);
		send_word(CMD_LINK, 3'd0, 1'b0);
		repeat (3) send_word(CMD_TICK, 3'd0, 1'b0);
		send_word(CMD_LINK, 3'd0, 1'b1);
		send_word(CMD_TICK, 3'd0, 1'b0);
		send_word(CMD_SENSOR, 3'd0, 1'b0);
		send_word(CMD_TICK, 3'd0, 1'b0);
		send_word(CMD_DB, 3'd0, 1'b0);
		send_word(CMD_TICK, 3'd0, 1'b0);
		send_word(CMD_STORAGE, 3'd0, 1'b0);
		send_word(CMD_SENSOR, 3'd7, 1'b0);
		send_word(CMD_TICK, 3'd0, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		apply_limits(random_limits(8));
		random_stream(400);
		wait_idle();
	endtask

	// Full-scale limits on half the timers, a limit of one on the rest
	task automatic test_random_sender_gaps();
		cfg_regs_t s;
		s = '{run_flip_active: 10'd1, run_flip_idle: 10'd1023, run_period: 10'd1,
			link_timeout: 10'd1023, sensor_flip: 10'd1, sensor_period: 10'd1023,
			fault_flip: 10'd1, fault_period: 10'd1023};
		send_idle_pct = 68;
		recv_stall_pct = 0;
		apply_limits(s);
		random_stream(400);
		wait_idle();
	endtask

	task automatic test_random_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 68;
		apply_limits(random_limits(16));
		random_stream(400);
		wait_idle();
	endtask

	task automatic test_random_both_idle();
		send_idle_pct = 31;
		recv_stall_pct = 31;
		apply_limits(CFG_RESET);
		random_stream(400);
		wait_idle();
	endtask

	initial begin
		in_valid <= 1'b0;
		command <= CMD_TICK;
		sensor_number <= '0;
		status_value <= 1'b0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RUN_FLIP_ACTIVE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		reports = 0;
		words_in = 0;
		results_checked = 0;
		reg_writes = 0;
		clear_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_command_set();
		test_zero_limits();
		test_random_no_idle();
		test_random_sender_gaps();
		test_random_receiver_stall();
		test_random_both_idle();

		$display("Sent %0d words and checked %0d pin results over %0d register writes,",
			words_in, results_checked, reg_writes);
		$display("with zero, minimum, full-scale and reset limits under four idling mixes.");
		if (fail_count == 0 && pins_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d failures, %0d results still pending", fail_count, pins_due.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
